[rtl/crfab_pkg.sv]
package crfab_pkg;

	localparam int DEF_FB_WIDTH  = 128;
	localparam int DEF_FB_HEIGHT = 128;

	localparam int PIX_W   = 32;
	localparam int CNT_W   = 15;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [31:0] FILL_COLOR_RST = 32'hFF00_0000;
	localparam logic [7:0]  ACTIVE_W_RST   = 8'd128;
	localparam logic [7:0]  ACTIVE_H_RST   = 8'd128;
	localparam logic [7:0]  ALPHA_ONE      = 8'd255;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_FILL  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILL_COLOR    = 2'd0,
		REG_BLEND_MODE    = 2'd1,
		REG_ACTIVE_WIDTH  = 2'd2,
		REG_ACTIVE_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CH_R = 2'd0,
		CH_G = 2'd1,
		CH_B = 2'd2
	} chan_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic signed [15:0] rect_width;
		logic signed [15:0] rect_height;
		logic [31:0]        clear_color;
	} item_t;

	typedef struct packed {
		logic [31:0]      read_color;
		logic [CNT_W-1:0] pixels_written;
	} result_t;

	// operands of the shared channel blend unit
	typedef struct packed {
		logic [PIX_W-1:0] src;
		logic [PIX_W-1:0] dst;
		chan_t            ch;
	} blend_op_t;

endpackage

[rtl/clipped_rect_fill_alpha_blend.sv]
// Rectangle blitter over an on-chip RGBA store of FB_WIDTH x FB_HEIGHT pixels.
// Issue a command with start while busy is low; exactly one result follows,
// shown for a single cycle with done high, and the receiver cannot stall it,
// so capture it on that cycle. A clear, or a fill in copy mode, writes each
// pixel in turn between setup and result. A fill in blend mode takes, per pixel,
// a store read, its registered return, and three passes through the one shared
// channel multiply-add unit (red, green, blue). A read inside the active area
// waits for the registered store return; any other command writing no pixel
// goes from setup to result. The store has no reset and no clearing pass:
// clear it before reading or blending. Write configuration only while idle.
module clipped_rect_fill_alpha_blend import crfab_pkg::*; #(
	parameter int FB_WIDTH  = DEF_FB_WIDTH,
	parameter int FB_HEIGHT = DEF_FB_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SETUP  = 6'b000010,
		ST_PIX    = 6'b000100,
		ST_RWAIT  = 6'b001000,
		ST_BLEND  = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q;

	logic [31:0] fill_color_q;
	logic        blend_mode_q;
	logic [7:0]  active_width_q;
	logic [7:0]  active_height_q;

	item_t            item_q;
	logic [31:0]      color_q;
	logic             blend_q;
	logic [7:0]       px_q, py_q, x0_q, x1_q, y1_q;
	logic [AW-1:0]    row_base_q;
	logic [31:0]      dst_q;
	logic [15:0]      res_q;
	chan_t            ch_q;
	logic [31:0]      rd_q;
	logic [CNT_W-1:0] cnt_q;

	// clipping
	logic [7:0]         aw, ah;
	logic signed [17:0] xs, ys, ws, hs, xe, ye, aws, ahs;
	logic signed [17:0] x0c, y0c, x1c, y1c;
	logic               fill_ok, clear_ok, rd_ok, loop_ok;
	logic [7:0]         sel_x0, sel_y0, sel_x1, sel_y1;
	logic [AW-1:0]      row0, rd_pix_addr, cur_addr;
	logic               last_x, last_y;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	blend_op_t  bop;
	logic [7:0] bchan;

	always_comb begin
		aw = (int'(active_width_q) > FB_WIDTH) ? 8'(FB_WIDTH) : active_width_q;
		ah = (int'(active_height_q) > FB_HEIGHT) ? 8'(FB_HEIGHT) : active_height_q;
		xs  = 18'(item_q.x_pos);
		ys  = 18'(item_q.y_pos);
		ws  = 18'(item_q.rect_width);
		hs  = 18'(item_q.rect_height);
		aws = $signed({10'b0, aw});
		ahs = $signed({10'b0, ah});
		xe  = xs + ws;
		ye  = ys + hs;
		x0c = (xs < 0) ? 18'sd0 : xs;
		y0c = (ys < 0) ? 18'sd0 : ys;
		x1c = (xe > aws) ? aws : xe;
		y1c = (ye > ahs) ? ahs : ye;
		fill_ok  = (ws > 0) && (hs > 0) && (x0c < x1c) && (y0c < y1c);
		clear_ok = (aw != 8'd0) && (ah != 8'd0);
		rd_ok    = (xs >= 0) && (ys >= 0) && (xs < aws) && (ys < ahs);
		if (item_q.cmd == CMD_CLEAR) begin
			sel_x0  = 8'd0;
			sel_y0  = 8'd0;
			sel_x1  = aw;
			sel_y1  = ah;
			loop_ok = clear_ok;
		end else begin
			sel_x0  = x0c[7:0];
			sel_y0  = y0c[7:0];
			sel_x1  = x1c[7:0];
			sel_y1  = y1c[7:0];
			loop_ok = (item_q.cmd == CMD_FILL) && fill_ok;
		end
		row0        = AW'(int'(sel_y0) * FB_WIDTH);
		rd_pix_addr = AW'(int'(ys[7:0]) * FB_WIDTH) + AW'(xs[7:0]);
		cur_addr    = row_base_q + AW'(px_q);
		last_x      = ({1'b0, px_q} + 9'd1) == {1'b0, x1_q};
		last_y      = ({1'b0, py_q} + 9'd1) == {1'b0, y1_q};
	end

	assign bop = '{src: fill_color_q, dst: dst_q, ch: ch_q};

	crfab_blend_unit u_blend (
		.op  (bop),
		.chan(bchan)
	);

	always_comb begin
		ram_raddr = (state_q == ST_SETUP) ? rd_pix_addr : cur_addr;
		ram_we    = ((state_q == ST_PIX) && !blend_q) ||
		            ((state_q == ST_BLEND) && (ch_q == CH_B));
		ram_wdata = blend_q ? {dst_q[31:24], bchan, res_q} : color_q;
	end

	crfab_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cur_addr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_color_q    <= FILL_COLOR_RST;
			blend_mode_q    <= 1'b0;
			active_width_q  <= ACTIVE_W_RST;
			active_height_q <= ACTIVE_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_FILL_COLOR:    fill_color_q    <= cfg_data;
				REG_BLEND_MODE:    blend_mode_q    <= cfg_data[0];
				REG_ACTIVE_WIDTH:  active_width_q  <= cfg_data[7:0];
				REG_ACTIVE_HEIGHT: active_height_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (loop_ok) begin
						state_q <= ST_PIX;
					end else if ((item_q.cmd == CMD_READ) && rd_ok) begin
						state_q <= ST_RWAIT;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_PIX: begin
					if (blend_q) begin
						state_q <= ST_RWAIT;
					end else if (last_x && last_y) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RWAIT: begin
					state_q <= (item_q.cmd == CMD_READ) ? ST_RESULT : ST_BLEND;
				end
				ST_BLEND: begin
					if (ch_q == CH_B) begin
						state_q <= (last_x && last_y) ? ST_RESULT : ST_PIX;
					end
				end
				ST_RESULT: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= item;
			end
			ST_SETUP: begin
				color_q    <= (item_q.cmd == CMD_CLEAR) ? item_q.clear_color : fill_color_q;
				blend_q    <= (item_q.cmd == CMD_FILL) && blend_mode_q;
				x0_q       <= sel_x0;
				x1_q       <= sel_x1;
				y1_q       <= sel_y1;
				px_q       <= sel_x0;
				py_q       <= sel_y0;
				row_base_q <= row0;
				rd_q       <= '0;
				cnt_q      <= '0;
			end
			ST_RWAIT: begin
				if (item_q.cmd == CMD_READ) begin
					rd_q <= ram_rdata;
				end else begin
					dst_q <= ram_rdata;
					ch_q  <= CH_R;
				end
			end
			ST_BLEND: begin
				unique case (ch_q)
					CH_R:    res_q[7:0]  <= bchan;
					CH_G:    res_q[15:8] <= bchan;
					default: ;
				endcase
				ch_q <= (ch_q == CH_R) ? CH_G : CH_B;
			end
			default: ;
		endcase
		// advance the pixel walk after each write
		if (ram_we) begin
			if (cnt_q != CNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (last_x) begin
				px_q       <= x0_q;
				py_q       <= py_q + 8'd1;
				row_base_q <= row_base_q + AW'(FB_WIDTH);
			end else begin
				px_q <= px_q + 8'd1;
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_RESULT);
	assign result = '{read_color: rd_q, pixels_written: cnt_q};

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not raise busy");

	a_read_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (item_q.cmd == CMD_READ)) |-> (result.pixels_written == '0))
		else $error("read reported written pixels");

	a_color_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (item_q.cmd != CMD_READ)) |-> (result.read_color == '0))
		else $error("non-read transaction returned a color");

	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((int'(cur_addr) < DEPTH) && (px_q < x1_q) && (py_q < y1_q)))
		else $error("pixel write outside clipped area");

endmodule

[rtl/crfab_ram.sv]
module crfab_ram import crfab_pkg::*; #(
	parameter int WIDTH = PIX_W,
	parameter int DEPTH = DEF_FB_WIDTH * DEF_FB_HEIGHT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/crfab_blend_unit.sv]
module crfab_blend_unit import crfab_pkg::*; (
	input  blend_op_t  op,
	output logic [7:0] chan
);

	logic [7:0]  a;
	logic [7:0]  na;
	logic [7:0]  s;
	logic [7:0]  d;
	logic [15:0] v;
	logic [16:0] q;

	always_comb begin
		a  = op.src[31:24];
		na = ALPHA_ONE - a;
		unique case (op.ch)
			CH_R: begin
				s = op.src[7:0];
				d = op.dst[7:0];
			end
			CH_G: begin
				s = op.src[15:8];
				d = op.dst[15:8];
			end
			CH_B: begin
				s = op.src[23:16];
				d = op.dst[23:16];
			end
			default: begin
				s = '0;
				d = '0;
			end
		endcase
		v = ({8'b0, d} * {8'b0, na}) + ({8'b0, s} * {8'b0, a});
		// exact floor(v / 255) for any v up to 65025, the largest value v takes here
		q = 17'(v) + 17'd1 + 17'(v[15:8]);
		chan = q[15:8];
	end

endmodule
